// ----- hw/rtl/bstsc_pkg.sv -----
package bstsc_pkg;

  localparam int MAX_TOKEN_LEN = 23;
  localparam int LEN_W = 5;
  localparam int VALUE_W = 31;
  localparam int POS_W = 16;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // token kinds
  localparam logic [2:0] KIND_NUMBER  = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_OPER    = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_INVALID = 3'd4;

  // scanner modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    logic [2:0]         kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   start;
    logic [LEN_W-1:0]   len;
    logic [7:0]         lead;
    logic               ovf;
    logic               last;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
           (c == CH_EQ) || (c == CH_LT) || (c == CH_GT);
  endfunction

endpackage

// ----- hw/rtl/byte_stream_token_scanner_core.sv -----
// Channel | signals                            | direction
// --------+------------------------------------+----------
// in      | in_valid, in_stall, char_in        | byte in
// out     | out_valid, out_stall, token_kind,  | token out
//         | number_value, start_pos, token_len,|
//         | lead_char, value_overflow, last    |
//
// One byte is scanned in the cycle it is transferred; its tokens (zero, one
// or two) land in a 4-entry result queue the same edge and leave one per cycle
// while out_stall is low. A byte is taken whenever the queue holds two free slots,
// so input runs at one byte per cycle unless out_stall or two-token bytes back it up.
// rst is synchronous: scanner back to start, position zero, queue empty.
// out_stall only fills the queue; in_stall rises once fewer than two slots are free.
module byte_stream_token_scanner_core
  import bstsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         token_kind,
  output logic [VALUE_W-1:0] number_value,
  output logic [POS_W-1:0]   start_pos,
  output logic [LEN_W-1:0]   token_len,
  output logic [7:0]         lead_char,
  output logic               value_overflow,
  output logic               last
);

  // scanner state
  logic [1:0]         scan_mode, scan_mode_next;
  logic [POS_W-1:0]   position, position_next;
  logic [POS_W-1:0]   token_start, token_start_next;
  logic [LEN_W-1:0]   run_length, run_length_next;
  logic [VALUE_W-1:0] value_acc, value_acc_next;
  logic               acc_overflow, acc_overflow_next;
  logic [7:0]         first_byte, first_byte_next;

  // result queue
  result_t    queue [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;

  logic       accept, pop;
  logic       emit_close, emit_new, run_continues;
  result_t    close_res, new_res, push0, push1;
  logic [1:0] push_n;
  logic [34:0] acc_times10;
  logic [3:0]  digit;

  assign in_stall = (count > 3'd2);
  assign accept   = in_valid && !in_stall;
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;

  assign digit       = char_in[3:0];
  assign acc_times10 = ({4'b0, value_acc} << 3) + ({4'b0, value_acc} << 1) +
                       {31'b0, digit};

  always_comb begin
    scan_mode_next    = scan_mode;
    position_next     = position;
    token_start_next  = token_start;
    run_length_next   = run_length;
    value_acc_next    = value_acc;
    acc_overflow_next = acc_overflow;
    first_byte_next   = first_byte;
    emit_close        = 1'b0;
    emit_new          = 1'b0;
    run_continues     = 1'b0;
    close_res         = '0;
    new_res           = '0;

    // extend or close an open run
    case (scan_mode)
      MODE_NUM: begin
        if (is_digit(char_in) && (run_length < LEN_W'(MAX_TOKEN_LEN))) begin
          run_continues = 1'b1;
          if (acc_overflow || (acc_times10 > {4'b0, VALUE_MAX})) begin
            value_acc_next    = VALUE_MAX;
            acc_overflow_next = 1'b1;
          end else begin
            value_acc_next = acc_times10[VALUE_W-1:0];
          end
          run_length_next = run_length + LEN_W'(1);
          position_next   = position + POS_W'(1);
        end else begin
          emit_close      = 1'b1;
          close_res.kind  = KIND_NUMBER;
          close_res.value = value_acc;
          close_res.start = token_start;
          close_res.len   = run_length;
          close_res.lead  = first_byte;
          close_res.ovf   = acc_overflow;
        end
      end
      MODE_IDENT: begin
        if ((is_alpha(char_in) || is_digit(char_in)) &&
            (run_length < LEN_W'(MAX_TOKEN_LEN))) begin
          run_continues   = 1'b1;
          run_length_next = run_length + LEN_W'(1);
          position_next   = position + POS_W'(1);
        end else begin
          emit_close      = 1'b1;
          close_res.kind  = KIND_IDENT;
          close_res.start = token_start;
          close_res.len   = run_length;
          close_res.lead  = first_byte;
        end
      end
      default: ;
    endcase

    // byte not absorbed by a run: scan it from start
    if (!run_continues) begin
      scan_mode_next = MODE_START;
      new_res.start  = position;
      new_res.lead   = char_in;
      new_res.len    = LEN_W'(1);
      position_next  = position + POS_W'(1);
      if (char_in == CH_NUL) begin
        emit_new      = 1'b1;
        new_res.kind  = KIND_END;
        new_res.lead  = '0;
        new_res.len   = '0;
        position_next = '0;
      end else if ((char_in == CH_SPACE) || (char_in == CH_TAB) || (char_in == CH_LF)) begin
        // whitespace: just advance
      end else if (is_digit(char_in) || is_alpha(char_in)) begin
        scan_mode_next    = is_digit(char_in) ? MODE_NUM : MODE_IDENT;
        token_start_next  = position;
        run_length_next   = LEN_W'(1);
        first_byte_next   = char_in;
        value_acc_next    = is_digit(char_in) ? {27'b0, digit} : '0;
        acc_overflow_next = 1'b0;
      end else begin
        emit_new     = 1'b1;
        new_res.kind = is_op(char_in) ? KIND_OPER : KIND_INVALID;
      end
    end

    close_res.last = !emit_new;
    new_res.last   = 1'b1;
  end

  always_comb begin
    push0  = emit_close ? close_res : new_res;
    push1  = new_res;
    push_n = accept ? ({1'b0, emit_close} + {1'b0, emit_new}) : 2'd0;
  end

  assign count_next = count + {1'b0, push_n} - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode    <= MODE_START;
      position     <= '0;
      token_start  <= '0;
      run_length   <= '0;
      value_acc    <= '0;
      acc_overflow <= 1'b0;
      first_byte   <= '0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
    end else begin
      if (accept) begin
        scan_mode    <= scan_mode_next;
        position     <= position_next;
        token_start  <= token_start_next;
        run_length   <= run_length_next;
        value_acc    <= value_acc_next;
        acc_overflow <= acc_overflow_next;
        first_byte   <= first_byte_next;
      end
      wr_ptr <= wr_ptr + push_n;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

  // queue storage, payload only
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + 2'd1] <= push1;
    end
  end

  assign token_kind     = queue[rd_ptr].kind;
  assign number_value   = queue[rd_ptr].value;
  assign start_pos      = queue[rd_ptr].start;
  assign token_len      = queue[rd_ptr].len;
  assign lead_char      = queue[rd_ptr].lead;
  assign value_overflow = queue[rd_ptr].ovf;
  assign last           = queue[rd_ptr].last;

endmodule

// ----- tb/sv/token_stream_checker.sv -----
module token_stream_checker
  import bstsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         char_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         token_kind,
  input  logic [VALUE_W-1:0] number_value,
  input  logic [POS_W-1:0]   start_pos,
  input  logic [LEN_W-1:0]   token_len,
  input  logic [7:0]         lead_char,
  input  logic               value_overflow,
  input  logic               last,
  output int                 mismatches,
  output int                 pending,
  output int                 tokens_checked,
  output int                 saturated_seen
);

  localparam logic [7:0] DIG_LO   = 8'h30;
  localparam logic [7:0] DIG_HI   = 8'h39;
  localparam logic [7:0] UPPER_LO = 8'h41;
  localparam logic [7:0] UPPER_HI = 8'h5A;
  localparam logic [7:0] LOWER_LO = 8'h61;
  localparam logic [7:0] LOWER_HI = 8'h7A;

  typedef enum logic [2:0] {
    BC_NUL, BC_BLANK, BC_DIGIT, BC_ALPHA, BC_OPER, BC_OTHER
  } byte_class_e;

  result_t            expected_tokens[$];
  logic [1:0]         mode;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   tok_start;
  logic [LEN_W-1:0]   run_len;
  logic [VALUE_W-1:0] acc;
  logic               acc_ovf;
  logic [7:0]         lead;
  int                 bad_tokens;
  int                 good_count;
  int                 sat_count;

  function automatic byte_class_e classify(input logic [7:0] c);
    if (c == CH_NUL) return BC_NUL;
    if (c == CH_SPACE || c == CH_TAB || c == CH_LF) return BC_BLANK;
    if (c >= DIG_LO && c <= DIG_HI) return BC_DIGIT;
    if ((c >= UPPER_LO && c <= UPPER_HI) || (c >= LOWER_LO && c <= LOWER_HI) ||
        c == CH_UNDER) return BC_ALPHA;
    case (c)
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ, CH_LT, CH_GT: return BC_OPER;
      default: return BC_OTHER;
    endcase
  endfunction

  function automatic result_t make_token(input logic [2:0] k, input logic [VALUE_W-1:0] v,
                                         input logic [POS_W-1:0] s, input logic [LEN_W-1:0] n,
                                         input logic [7:0] first, input logic o);
    result_t t;
    t.kind  = k;
    t.value = v;
    t.start = s;
    t.len   = n;
    t.lead  = first;
    t.ovf   = o;
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic string show(input result_t t);
    return $sformatf("kind=%0d value=%0d pos=%0d len=%0d lead=%02h ovf=%0b last=%0b",
                     t.kind, t.value, t.start, t.len, t.lead, t.ovf, t.last);
  endfunction

  task automatic open_run(input logic [1:0] m, input logic [7:0] c);
    mode      = m;
    tok_start = pos;
    run_len   = LEN_W'(1);
    lead      = c;
    acc       = (m == MODE_NUM) ? VALUE_W'(c - DIG_LO) : '0;
    acc_ovf   = 1'b0;
    pos       = pos + 1'b1;
  endtask

  // one byte in, zero to two tokens queued
  task automatic scan_byte(input logic [7:0] c);
    byte_class_e         cls;
    result_t             toks[2];
    int                  n;
    logic [VALUE_W+3:0]  grown;
    cls = classify(c);
    n = 0;
    if (mode == MODE_NUM && cls == BC_DIGIT && run_len < MAX_TOKEN_LEN) begin
      grown = 35'(acc) * 35'd10 + 35'(c - DIG_LO);
      if (acc_ovf || grown > 35'(VALUE_MAX)) begin
        acc     = VALUE_MAX;
        acc_ovf = 1'b1;
      end else begin
        acc = grown[VALUE_W-1:0];
      end
      run_len = run_len + 1'b1;
      pos     = pos + 1'b1;
      return;
    end
    if (mode == MODE_IDENT && (cls == BC_DIGIT || cls == BC_ALPHA) &&
        run_len < MAX_TOKEN_LEN) begin
      run_len = run_len + 1'b1;
      pos     = pos + 1'b1;
      return;
    end
    // the open run (if any) closes, then the byte is scanned afresh
    if (mode == MODE_NUM) begin
      toks[n] = make_token(KIND_NUMBER, acc, tok_start, run_len, lead, acc_ovf);
      n++;
    end else if (mode == MODE_IDENT) begin
      toks[n] = make_token(KIND_IDENT, '0, tok_start, run_len, lead, 1'b0);
      n++;
    end
    mode = MODE_START;
    case (cls)
      BC_NUL: begin
        toks[n] = make_token(KIND_END, '0, pos, '0, '0, 1'b0);
        n++;
        pos = '0;
      end
      BC_BLANK: pos = pos + 1'b1;
      BC_DIGIT: open_run(MODE_NUM, c);
      BC_ALPHA: open_run(MODE_IDENT, c);
      BC_OPER: begin
        toks[n] = make_token(KIND_OPER, '0, pos, LEN_W'(1), c, 1'b0);
        n++;
        pos = pos + 1'b1;
      end
      default: begin
        toks[n] = make_token(KIND_INVALID, '0, pos, LEN_W'(1), c, 1'b0);
        n++;
        pos = pos + 1'b1;
      end
    endcase
    if (n > 0) toks[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_tokens.push_back(toks[i]);
  endtask

  task automatic check_token();
    result_t got;
    result_t want;
    got = make_token(token_kind, number_value, start_pos, token_len, lead_char,
                     value_overflow);
    got.last = last;
    if (expected_tokens.size() == 0) begin
      bad_tokens++;
      if (bad_tokens <= 10) $display("token with none pending: %s", show(got));
      return;
    end
    want = expected_tokens.pop_front();
    if (got.kind !== want.kind || got.value !== want.value || got.start !== want.start ||
        got.len !== want.len || got.lead !== want.lead || got.ovf !== want.ovf ||
        got.last !== want.last) begin
      bad_tokens++;
      if (bad_tokens <= 10) begin
        $display("token mismatch  exp: %s", show(want));
        $display("                got: %s", show(got));
      end
    end else begin
      good_count++;
      if (want.kind == KIND_NUMBER && want.ovf) sat_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode       = MODE_START;
      pos        = '0;
      tok_start  = '0;
      run_len    = '0;
      acc        = '0;
      acc_ovf    = 1'b0;
      lead       = '0;
      bad_tokens = 0;
      good_count = 0;
      sat_count  = 0;
      expected_tokens.delete();
    end else begin
      if (out_valid && !out_stall) check_token();
      if (in_valid && !in_stall) scan_byte(char_in);
    end
    mismatches     <= bad_tokens;
    pending        <= expected_tokens.size();
    tokens_checked <= good_count;
    saturated_seen <= sat_count;
  end

endmodule

// ----- tb/sv/byte_stream_token_scanner_core_tb.sv -----
module byte_stream_token_scanner_core_tb;
  import bstsc_pkg::*;

  // Longest stretch without any transfer that a correct run can show is the
  // receiver hold-off (HOLD_LEN) plus random stall streaks; this is far above.
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int HOLD_LEN    = 80;

  localparam logic [7:0] DIG0    = 8'h30;
  localparam logic [7:0] DIG9    = 8'h39;
  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] UPPER_A = 8'h41;
  localparam logic [7:0] CH_AT   = 8'h40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         char_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         token_kind;
  logic [VALUE_W-1:0] number_value;
  logic [POS_W-1:0]   start_pos;
  logic [LEN_W-1:0]   token_len;
  logic [7:0]         lead_char;
  logic               value_overflow;
  logic               last;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int bytes_sent = 0;
  int solid_bytes = 0;   // non-blank bytes; run_phase counts these
  int idle_cycles = 0;

  int mismatches;
  int pending;
  int tokens_checked;
  int saturated_seen;

  byte_stream_token_scanner_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_in       (char_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .token_kind    (token_kind),
    .number_value  (number_value),
    .start_pos     (start_pos),
    .token_len     (token_len),
    .lead_char     (lead_char),
    .value_overflow(value_overflow),
    .last          (last)
  );

  // Predicts and checks every token; hands back the failure count.
  token_stream_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_in       (char_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .token_kind    (token_kind),
    .number_value  (number_value),
    .start_pos     (start_pos),
    .token_len     (token_len),
    .lead_char     (lead_char),
    .value_overflow(value_overflow),
    .last          (last),
    .mismatches    (mismatches),
    .pending       (pending),
    .tokens_checked(tokens_checked),
    .saturated_seen(saturated_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stall, or a long hold-off counted down here once the
  // stimulus asks for it.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: any transfer on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d tokens pending",
               idle_cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One byte transfer. Entered and left at a falling edge; valid stays high
  // across back-to-back bytes and only drops during a random gap.
  task automatic put_byte(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (c != CH_SPACE && c != CH_TAB && c != CH_LF) solid_bytes++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // Pause the sender until every predicted token has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_oper(input int i);
    case (i)
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      3: return CH_SLASH;
      4: return CH_EQ;
      5: return CH_LT;
      default: return CH_GT;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] pick_alpha();
    int r;
    r = $urandom_range(52);
    if (r < 26) return LOWER_A + 8'(r);
    if (r < 52) return UPPER_A + 8'(r - 26);
    return CH_UNDER;
  endfunction

  // Mostly short runs; one in five is 5 to 30 long and may pass the length cap or saturate.
  function automatic int pick_run_len();
    if ($urandom_range(99) < 80) return $urandom_range(1, 4);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_number(input int len);
    bit nines;
    nines = $urandom_range(1);
    for (int i = 0; i < len; i++)
      put_byte(nines ? DIG9 : DIG0 + 8'($urandom_range(9)));
  endtask

  task automatic send_ident(input int len);
    put_byte(pick_alpha());
    for (int i = 1; i < len; i++)
      put_byte(($urandom_range(3) == 0) ? DIG0 + 8'($urandom_range(9)) : pick_alpha());
  endtask

  // Well-formed token stream with random content; noise bytes and stream
  // ends mixed in, and runs often abut so one byte closes one token and
  // starts or emits another.
  task automatic send_fragment();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35)      send_number(pick_run_len());
    else if (pick < 65) send_ident(pick_run_len());
    else if (pick < 80) put_byte(pick_oper($urandom_range(6)));
    else if (pick < 90) put_byte(pick_blank());
    else if (pick < 95) put_byte(8'($urandom_range(255)));
    else                put_byte(CH_NUL);
    if ($urandom_range(1) == 1) put_byte(pick_blank());
  endtask

  task automatic run_phase(input int target);
    int base;
    base = solid_bytes;
    while (solid_bytes - base < target) send_fragment();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // phase 1: sender mostly busy, receiver mostly stalled
    send_idle_pct = 14;
    recv_idle_pct = 83;

    // directed: every operator, each blank, invalid extremes, identifier,
    // number closed by an invalid byte (two tokens from one byte),
    // identifier closed by end of stream, then a bare end at offset zero
    send_text("+-*/=<>");
    send_text(" \t\n");
    put_byte(8'hFF);
    put_byte(8'h01);
    send_text("A_z9 09");
    put_byte(CH_AT);
    put_byte(LOWER_A);
    put_byte(CH_NUL);
    put_byte(CH_NUL);

    run_phase(300);
    drain();

    // phase 2: sender mostly idle, receiver mostly ready
    send_idle_pct = 83;
    recv_idle_pct = 14;
    run_phase(300);
    drain();

    // phase 3: no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // long receiver hold-off while operators keep coming: queue fills and
    // the input stalls until the hold ends
    hold_cycles = HOLD_LEN;
    for (int i = 0; i < 40; i++) put_byte(pick_oper(i % 7));
    drain();

    run_phase(300);

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("scanned %0d bytes (%0d non-blank) across three stall mixes and a full queue",
             bytes_sent, solid_bytes);
    $display("%0d tokens matched, %0d of them saturated numbers", tokens_checked,
             saturated_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
